@@ hdl/tasmc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package tasmc_pkg;

   // Controller sequencer states.
   typedef enum logic [4:0] {
      ST_IDLE,
      ST_BYTE,
      ST_GOAL,
      ST_DELTA,
      ST_NULL,
      ST_DIV_DES,
      ST_DES,
      ST_SEC,
      ST_DIV_SEC,
      ST_RS,
      ST_PX,
      ST_DIV_PX,
      ST_PXC,
      ST_PY,
      ST_DIV_PY,
      ST_PYC,
      ST_APPLY,
      ST_TICK,
      ST_TX,
      ST_TY,
      ST_OUT
   } state_type;

   typedef logic [1:0] dir_type;

   localparam dir_type DIR_STOP = 2'd0;
   localparam dir_type DIR_FWD  = 2'd1;
   localparam dir_type DIR_BACK = 2'd2;

   // Receive phases of a packet.
   localparam logic [1:0] RX_HEADER = 2'd0;
   localparam logic [1:0] RX_X_MM   = 2'd1;
   localparam logic [1:0] RX_Y_MM   = 2'd2;
   localparam logic [1:0] RX_SPEED  = 2'd3;

   localparam logic [7:0] HEADER_BYTE = 8'd255;

   // Register indexes.
   localparam logic [2:0] REG_STEPS_PER_MM  = 3'd0;
   localparam logic [2:0] REG_MAX_STEP_RATE = 3'd1;
   localparam logic [2:0] REG_TIMER_HZ      = 3'd2;
   localparam logic [2:0] REG_PERIOD_MIN    = 3'd3;
   localparam logic [2:0] REG_PERIOD_MAX    = 3'd4;

   localparam logic [4:0]  SPM_RESET   = 5'd5;
   localparam logic [11:0] RATE_RESET  = 12'd340;
   localparam logic [22:0] TIMER_RESET = 23'd4000000;
   localparam logic [15:0] PMIN_RESET  = 16'd2000;
   localparam logic [15:0] PMAX_RESET  = 16'd60000;

   // Half-step coil pattern: bit0 A+, bit1 A-, bit2 B+, bit3 B-.
   function automatic logic [3:0] half_pattern(input logic [2:0] idx);
      logic [3:0] p;
      begin
         case (idx)
            3'd0: p = 4'h5;
            3'd1: p = 4'h1;
            3'd2: p = 4'h9;
            3'd3: p = 4'h8;
            3'd4: p = 4'hA;
            3'd5: p = 4'h2;
            3'd6: p = 4'h6;
            default: p = 4'h4;
         endcase
         return p;
      end
   endfunction

endpackage

`default_nettype wire

@@ hdl/two_axis_stepper_motion_controller.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Channel  Direction  Ports
// req      in         req_valid, req_stall, req_func, req_rx_byte
// rsp      out        rsp_valid, rsp_stall, rsp_x_phases .. rsp_packet_done
// csr      in         csr_we, csr_index, csr_wdata
//
// A header or position byte passes ST_BYTE and ST_OUT; a speed byte that gives a null
// move passes ST_BYTE, ST_GOAL, ST_DELTA, ST_NULL and ST_OUT. A speed byte that starts a
// move runs up to four bit-serial divisions on one shared restoring divider, one quotient
// bit per cycle (dividend width DVW = max(23, 12 + POS_BITS)). A tick runs ST_TICK, then
// ST_TX and ST_TY, each repeated for every half-step taken, then ST_OUT. Reset is synchronous
// and clears the state, configuration, axis and response-valid registers. A request is taken
// only while the sequencer is idle; a stalled response holds the sequencer in ST_OUT until taken.

module two_axis_stepper_motion_controller
   import tasmc_pkg::*;
#(
   parameter int POS_BITS    = 12,
   parameter int PERIOD_BITS = 16
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire logic                req_func,
   input  wire logic [7:0]          req_rx_byte,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output logic [3:0]               rsp_x_phases,
   output logic [3:0]               rsp_y_phases,
   output logic [POS_BITS-1:0]      rsp_pos_x,
   output logic [POS_BITS-1:0]      rsp_pos_y,
   output logic                     rsp_x_moving,
   output logic                     rsp_y_moving,
   output logic [15:0]              rsp_next_interval,
   output logic                     rsp_packet_done,
   input  wire logic                csr_we,
   input  wire logic [2:0]          csr_index,
   input  wire logic [22:0]         csr_wdata
);

   localparam int PB  = PERIOD_BITS;
   localparam int AW  = PERIOD_BITS + 1;
   localparam int IW  = (PERIOD_BITS > 16) ? PERIOD_BITS : 16;
   localparam int DVW = ((12 + POS_BITS) > 23) ? (12 + POS_BITS) : 23;
   localparam int DSW = (POS_BITS > 12) ? POS_BITS : 12;
   localparam int CW  = $clog2(DVW + 1);

   state_type state_ff, state_in;

   logic [7:0]        byte_ff, byte_in;
   logic [4:0]        spm_ff, spm_in;
   logic [11:0]       msr_ff, msr_in;
   logic [22:0]       thz_ff, thz_in;
   logic [15:0]       pmin_ff, pmin_in;
   logic [15:0]       pmax_ff, pmax_in;
   logic [1:0]        rx_phase_ff, rx_phase_in;
   logic [7:0]        held_x_ff, held_x_in, held_y_ff, held_y_in;
   logic [POS_BITS-1:0] cur_x_ff, cur_x_in, cur_y_ff, cur_y_in;
   logic [POS_BITS-1:0] goal_x_ff, goal_x_in, goal_y_ff, goal_y_in;
   logic [POS_BITS-1:0] ax_ff, ax_in, ay_ff, ay_in;
   dir_type           dir_x_ff, dir_x_in, dir_y_ff, dir_y_in;
   logic [PB-1:0]     per_x_ff, per_x_in, per_y_ff, per_y_in;
   logic [AW-1:0]     acc_x_ff, acc_x_in, acc_y_ff, acc_y_in;
   logic [2:0]        idx_x_ff, idx_x_in, idx_y_ff, idx_y_in;
   logic [1:0]        energ_ff, energ_in;
   logic [11:0]       des_ff, des_in, rs_ff, rs_in;
   logic [IW-1:0]     ival_ff, ival_in;
   logic              done_ff, done_in;
   logic [DVW-1:0]    num_ff, num_in;
   logic [DSW-1:0]    den_ff, den_in, rem_ff, rem_in;
   logic [CW-1:0]     cnt_ff, cnt_in;

   logic              rv_ff, rv_in;
   logic [3:0]        rxp_ff, rxp_in, ryp_ff, ryp_in;
   logic [POS_BITS-1:0] rpx_ff, rpx_in, rpy_ff, rpy_in;
   logic              rmx_ff, rmx_in, rmy_ff, rmy_in, rdone_ff, rdone_in;
   logic [15:0]       rival_ff, rival_in;

   logic              req_take;
   logic              out_free;
   logic              div_last;
   logic [DSW:0]      rem_sh;
   logic              q_bit;
   logic [PB-1:0]     pmax_pb;
   logic [PB-1:0]     per_clamped;
   logic [DVW-1:0]    t_clamp;
   logic [IW-1:0]     n_c;
   logic              ax_ge;
   logic [POS_BITS-1:0] prim_c, sec_c;
   logic [11:0]       rate_x_c, rate_y_c;
   logic              step_x, step_y;
   logic [POS_BITS-1:0] nx_cur_x, nx_cur_y;

   assign req_take = req_valid && !req_stall;
   assign out_free = !rv_ff || !rsp_stall;
   assign div_last = (cnt_ff == CW'(1));
   assign pmax_pb  = PB'(pmax_ff);

   // One restoring division step per cycle; the dividend register fills with the quotient.
   assign rem_sh = {rem_ff, num_ff[DVW-1]};
   assign q_bit  = (rem_sh >= {1'b0, den_ff});

   always_comb begin
      t_clamp = num_ff;
      if (t_clamp < DVW'(pmin_ff)) begin
         t_clamp = DVW'(pmin_ff);
      end
      if (t_clamp > DVW'(pmax_ff)) begin
         t_clamp = DVW'(pmax_ff);
      end
      per_clamped = PB'(t_clamp);
   end

   // Scheduled interval: shorter period among the moving axes, else the longest period.
   always_comb begin
      n_c = IW'(pmax_ff);
      if (dir_x_ff != DIR_STOP) begin
         n_c = IW'(per_x_ff);
      end
      if (dir_y_ff != DIR_STOP) begin
         if (dir_x_ff == DIR_STOP) begin
            n_c = IW'(per_y_ff);
         end else if (IW'(per_y_ff) < n_c) begin
            n_c = IW'(per_y_ff);
         end
      end
      if (n_c == IW'(0)) begin
         n_c = IW'(pmax_ff);
      end
   end

   assign ax_ge    = (ax_ff >= ay_ff);
   assign prim_c   = ax_ge ? ax_ff : ay_ff;
   assign sec_c    = ax_ge ? ay_ff : ax_ff;
   assign rate_x_c = ax_ge ? des_ff : rs_ff;
   assign rate_y_c = ax_ge ? rs_ff : des_ff;

   assign step_x   = (dir_x_ff != DIR_STOP) && (acc_x_ff >= {1'b0, per_x_ff});
   assign step_y   = (dir_y_ff != DIR_STOP) && (acc_y_ff >= {1'b0, per_y_ff});
   assign nx_cur_x = (dir_x_ff == DIR_FWD) ? cur_x_ff + 1'b1 : cur_x_ff - 1'b1;
   assign nx_cur_y = (dir_y_ff == DIR_FWD) ? cur_y_ff + 1'b1 : cur_y_ff - 1'b1;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               state_in = req_func ? ST_TICK : ST_BYTE;
            end
         end
         ST_BYTE: state_in = (rx_phase_ff == RX_SPEED) ? ST_GOAL : ST_OUT;
         ST_GOAL: state_in = ST_DELTA;
         ST_DELTA: state_in = ST_NULL;
         ST_NULL: begin
            state_in = (ax_ff == '0 && ay_ff == '0) ? ST_OUT : ST_DIV_DES;
         end
         ST_DIV_DES: state_in = div_last ? ST_DES : ST_DIV_DES;
         ST_DES: state_in = ST_SEC;
         ST_SEC: state_in = (sec_c != '0) ? ST_DIV_SEC : ST_PX;
         ST_DIV_SEC: state_in = div_last ? ST_RS : ST_DIV_SEC;
         ST_RS: state_in = ST_PX;
         ST_PX: state_in = (rate_x_c != '0) ? ST_DIV_PX : ST_PY;
         ST_DIV_PX: state_in = div_last ? ST_PXC : ST_DIV_PX;
         ST_PXC: state_in = ST_PY;
         ST_PY: state_in = (rate_y_c != '0) ? ST_DIV_PY : ST_APPLY;
         ST_DIV_PY: state_in = div_last ? ST_PYC : ST_DIV_PY;
         ST_PYC: state_in = ST_APPLY;
         ST_APPLY: state_in = ST_OUT;
         ST_TICK: state_in = ST_TX;
         ST_TX: state_in = step_x ? ST_TX : ST_TY;
         ST_TY: state_in = step_y ? ST_TY : ST_OUT;
         ST_OUT: state_in = out_free ? ST_IDLE : ST_OUT;
         default: state_in = ST_IDLE;
      endcase
   end

   // Outputs of the sequencer.
   always_comb begin
      req_stall = (state_ff != ST_IDLE);
   end

   // Datapath.
   always_comb begin
      byte_in     = byte_ff;
      spm_in      = spm_ff;
      msr_in      = msr_ff;
      thz_in      = thz_ff;
      pmin_in     = pmin_ff;
      pmax_in     = pmax_ff;
      rx_phase_in = rx_phase_ff;
      held_x_in   = held_x_ff;
      held_y_in   = held_y_ff;
      cur_x_in    = cur_x_ff;
      cur_y_in    = cur_y_ff;
      goal_x_in   = goal_x_ff;
      goal_y_in   = goal_y_ff;
      ax_in       = ax_ff;
      ay_in       = ay_ff;
      dir_x_in    = dir_x_ff;
      dir_y_in    = dir_y_ff;
      per_x_in    = per_x_ff;
      per_y_in    = per_y_ff;
      acc_x_in    = acc_x_ff;
      acc_y_in    = acc_y_ff;
      idx_x_in    = idx_x_ff;
      idx_y_in    = idx_y_ff;
      energ_in    = energ_ff;
      des_in      = des_ff;
      rs_in       = rs_ff;
      ival_in     = ival_ff;
      done_in     = done_ff;
      num_in      = num_ff;
      den_in      = den_ff;
      rem_in      = rem_ff;
      cnt_in      = cnt_ff;
      rv_in       = rv_ff && rsp_stall;
      rxp_in      = rxp_ff;
      ryp_in      = ryp_ff;
      rpx_in      = rpx_ff;
      rpy_in      = rpy_ff;
      rmx_in      = rmx_ff;
      rmy_in      = rmy_ff;
      rival_in    = rival_ff;
      rdone_in    = rdone_ff;

      if (csr_we) begin
         case (csr_index)
            REG_STEPS_PER_MM:  spm_in  = csr_wdata[4:0];
            REG_MAX_STEP_RATE: msr_in  = csr_wdata[11:0];
            REG_TIMER_HZ:      thz_in  = csr_wdata;
            REG_PERIOD_MIN:    pmin_in = csr_wdata[15:0];
            REG_PERIOD_MAX:    pmax_in = csr_wdata[15:0];
            default: ;
         endcase
      end

      if (state_ff == ST_DIV_DES || state_ff == ST_DIV_SEC ||
          state_ff == ST_DIV_PX || state_ff == ST_DIV_PY) begin
         rem_in = q_bit ? DSW'(rem_sh - {1'b0, den_ff}) : DSW'(rem_sh);
         num_in = {num_ff[DVW-2:0], q_bit};
         cnt_in = cnt_ff - 1'b1;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               byte_in = req_rx_byte;
            end
         end
         ST_BYTE: begin
            ival_in = '0;
            done_in = 1'b0;
            case (rx_phase_ff)
               RX_HEADER: begin
                  if (byte_ff == HEADER_BYTE) begin
                     rx_phase_in = RX_X_MM;
                  end
               end
               RX_X_MM: begin
                  held_x_in   = byte_ff;
                  rx_phase_in = RX_Y_MM;
               end
               RX_Y_MM: begin
                  held_y_in   = byte_ff;
                  rx_phase_in = RX_SPEED;
               end
               default: begin
                  rx_phase_in = RX_HEADER;
                  done_in     = 1'b1;
               end
            endcase
         end
         ST_GOAL: begin
            goal_x_in = POS_BITS'(POS_BITS'(held_x_ff) * POS_BITS'(spm_ff));
            goal_y_in = POS_BITS'(POS_BITS'(held_y_ff) * POS_BITS'(spm_ff));
         end
         ST_DELTA: begin
            ax_in = (goal_x_ff >= cur_x_ff) ? goal_x_ff - cur_x_ff : cur_x_ff - goal_x_ff;
            ay_in = (goal_y_ff >= cur_y_ff) ? goal_y_ff - cur_y_ff : cur_y_ff - goal_y_ff;
         end
         ST_NULL: begin
            if (ax_ff == '0 && ay_ff == '0) begin
               dir_x_in = DIR_STOP;
               dir_y_in = DIR_STOP;
               per_x_in = pmax_pb;
               per_y_in = pmax_pb;
               acc_x_in = '0;
               acc_y_in = '0;
               energ_in = 2'b00;
            end else begin
               num_in = DVW'(byte_ff) * DVW'(msr_ff);
               den_in = DSW'(8'd255);
               rem_in = '0;
               cnt_in = CW'(DVW);
            end
         end
         ST_DES: begin
            des_in = 12'(num_ff);
            if (byte_ff != 8'd0 && num_ff == '0) begin
               des_in = 12'd1;
            end
            rs_in = '0;
         end
         ST_SEC: begin
            num_in = DVW'(des_ff) * DVW'(sec_c);
            den_in = DSW'(prim_c);
            rem_in = '0;
            cnt_in = CW'(DVW);
         end
         ST_RS: begin
            rs_in = (num_ff == '0) ? 12'd1 : 12'(num_ff);
         end
         ST_PX: begin
            if (rate_x_c == '0) begin
               per_x_in = pmax_pb;
            end else begin
               num_in = DVW'(thz_ff);
               den_in = DSW'(rate_x_c);
               rem_in = '0;
               cnt_in = CW'(DVW);
            end
         end
         ST_PXC: per_x_in = per_clamped;
         ST_PY: begin
            if (rate_y_c == '0) begin
               per_y_in = pmax_pb;
            end else begin
               num_in = DVW'(thz_ff);
               den_in = DSW'(rate_y_c);
               rem_in = '0;
               cnt_in = CW'(DVW);
            end
         end
         ST_PYC: per_y_in = per_clamped;
         ST_APPLY: begin
            dir_x_in = (goal_x_ff > cur_x_ff) ? DIR_FWD :
                       ((goal_x_ff < cur_x_ff) ? DIR_BACK : DIR_STOP);
            dir_y_in = (goal_y_ff > cur_y_ff) ? DIR_FWD :
                       ((goal_y_ff < cur_y_ff) ? DIR_BACK : DIR_STOP);
            if (ax_ff == '0) begin
               per_x_in = pmax_pb;
               acc_x_in = '0;
            end
            if (ay_ff == '0) begin
               per_y_in = pmax_pb;
               acc_y_in = '0;
            end
            energ_in = 2'b11;
         end
         ST_TICK: begin
            ival_in = n_c;
            done_in = 1'b0;
            acc_x_in = (dir_x_ff == DIR_STOP) ? '0 :
                       AW'((IW + 1)'(acc_x_ff) + (IW + 1)'(n_c));
            acc_y_in = (dir_y_ff == DIR_STOP) ? '0 :
                       AW'((IW + 1)'(acc_y_ff) + (IW + 1)'(n_c));
         end
         ST_TX: begin
            if (step_x) begin
               idx_x_in = (dir_x_ff == DIR_FWD) ? idx_x_ff + 3'd1 : idx_x_ff - 3'd1;
               cur_x_in = nx_cur_x;
               acc_x_in = acc_x_ff - {1'b0, per_x_ff};
               if (nx_cur_x == goal_x_ff) begin
                  dir_x_in    = DIR_STOP;
                  per_x_in    = pmax_pb;
                  acc_x_in    = '0;
                  energ_in[0] = 1'b0;
               end
            end
         end
         ST_TY: begin
            if (step_y) begin
               idx_y_in = (dir_y_ff == DIR_FWD) ? idx_y_ff + 3'd1 : idx_y_ff - 3'd1;
               cur_y_in = nx_cur_y;
               acc_y_in = acc_y_ff - {1'b0, per_y_ff};
               if (nx_cur_y == goal_y_ff) begin
                  dir_y_in    = DIR_STOP;
                  per_y_in    = pmax_pb;
                  acc_y_in    = '0;
                  energ_in[1] = 1'b0;
               end
            end
         end
         ST_OUT: begin
            if (out_free) begin
               rv_in    = 1'b1;
               rxp_in   = energ_ff[0] ? half_pattern(idx_x_ff) : 4'd0;
               ryp_in   = energ_ff[1] ? half_pattern(idx_y_ff) : 4'd0;
               rpx_in   = cur_x_ff;
               rpy_in   = cur_y_ff;
               rmx_in   = (dir_x_ff != DIR_STOP);
               rmy_in   = (dir_y_ff != DIR_STOP);
               rival_in = ival_ff[15:0];
               rdone_in = done_ff;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         spm_ff      <= SPM_RESET;
         msr_ff      <= RATE_RESET;
         thz_ff      <= TIMER_RESET;
         pmin_ff     <= PMIN_RESET;
         pmax_ff     <= PMAX_RESET;
         rx_phase_ff <= RX_HEADER;
         held_x_ff   <= '0;
         held_y_ff   <= '0;
         cur_x_ff    <= '0;
         cur_y_ff    <= '0;
         goal_x_ff   <= '0;
         goal_y_ff   <= '0;
         dir_x_ff    <= DIR_STOP;
         dir_y_ff    <= DIR_STOP;
         per_x_ff    <= PB'(PMAX_RESET);
         per_y_ff    <= PB'(PMAX_RESET);
         acc_x_ff    <= '0;
         acc_y_ff    <= '0;
         idx_x_ff    <= '0;
         idx_y_ff    <= '0;
         energ_ff    <= '0;
         rv_ff       <= 1'b0;
      end else begin
         state_ff    <= state_in;
         spm_ff      <= spm_in;
         msr_ff      <= msr_in;
         thz_ff      <= thz_in;
         pmin_ff     <= pmin_in;
         pmax_ff     <= pmax_in;
         rx_phase_ff <= rx_phase_in;
         held_x_ff   <= held_x_in;
         held_y_ff   <= held_y_in;
         cur_x_ff    <= cur_x_in;
         cur_y_ff    <= cur_y_in;
         goal_x_ff   <= goal_x_in;
         goal_y_ff   <= goal_y_in;
         dir_x_ff    <= dir_x_in;
         dir_y_ff    <= dir_y_in;
         per_x_ff    <= per_x_in;
         per_y_ff    <= per_y_in;
         acc_x_ff    <= acc_x_in;
         acc_y_ff    <= acc_y_in;
         idx_x_ff    <= idx_x_in;
         idx_y_ff    <= idx_y_in;
         energ_ff    <= energ_in;
         rv_ff       <= rv_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff  <= byte_in;
      ax_ff    <= ax_in;
      ay_ff    <= ay_in;
      des_ff   <= des_in;
      rs_ff    <= rs_in;
      ival_ff  <= ival_in;
      done_ff  <= done_in;
      num_ff   <= num_in;
      den_ff   <= den_in;
      rem_ff   <= rem_in;
      cnt_ff   <= cnt_in;
      rxp_ff   <= rxp_in;
      ryp_ff   <= ryp_in;
      rpx_ff   <= rpx_in;
      rpy_ff   <= rpy_in;
      rmx_ff   <= rmx_in;
      rmy_ff   <= rmy_in;
      rival_ff <= rival_in;
      rdone_ff <= rdone_in;
   end

   assign rsp_valid         = rv_ff;
   assign rsp_x_phases      = rxp_ff;
   assign rsp_y_phases      = ryp_ff;
   assign rsp_pos_x         = rpx_ff;
   assign rsp_pos_y         = rpy_ff;
   assign rsp_x_moving      = rmx_ff;
   assign rsp_y_moving      = rmy_ff;
   assign rsp_next_interval = rival_ff;
   assign rsp_packet_done   = rdone_ff;

endmodule

`default_nettype wire
